// File: sv/rmth_pkg.sv
// Shared types and constants for the two-heap running median block.
package rmth_pkg;

    localparam int CAPACITY   = 1024;
    localparam int HEAP_DEPTH = 512;
    localparam int HEAP_AW    = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = HEAP_AW + 1;
    localparam int SEEN_W     = 11;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               first;
    } in_t;

    typedef struct packed {
        logic signed [31:0] median;
        logic [SEEN_W-1:0]  items_seen;
        logic               overflow;
    } out_t;

    typedef enum logic [1:0] {
        HOP_NOP,
        HOP_PUSH,
        HOP_POP,
        HOP_CLEAR
    } heap_op_t;

    typedef struct packed {
        heap_op_t           op;
        logic signed [31:0] value;
    } heap_cmd_t;

    typedef struct packed {
        logic               idle;
        logic [CNT_W-1:0]   count;
        logic signed [31:0] top;
    } heap_stat_t;

endpackage

// File: sv/rmth_heap.sv
// Min-heap engine over one synchronous memory: push with sift-up, pop with sift-down.
module rmth_heap (
    input  logic                clk,
    input  logic                rst_n,
    input  rmth_pkg::heap_cmd_t cmd,
    output rmth_pkg::heap_stat_t stat
);
    import rmth_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_POP_TOP,
        S_POP_LAST,
        S_DN_L,
        S_DN_R,
        S_DN_CMP
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [HEAP_AW-1:0]        idx_reg, idx_next;
    logic signed [31:0]        val_reg, val_next;
    logic signed [31:0]        lv_reg, lv_next;
    logic signed [31:0]        top_reg, top_next;
    logic                      rv_ok_reg, rv_ok_next;

    logic signed [31:0]        mem [HEAP_DEPTH];
    logic signed [31:0]        rd_data_reg;
    logic [HEAP_AW-1:0]        rd_addr;
    logic                      wr_en;
    logic [HEAP_AW-1:0]        wr_addr;
    logic signed [31:0]        wr_data;

    logic [HEAP_AW-1:0]        parent_idx;
    logic [CNT_W-1:0]          lidx;
    logic [CNT_W-1:0]          ridx;
    logic [CNT_W-1:0]          cnt_dec;
    logic signed [31:0]        best;
    logic [HEAP_AW-1:0]        best_idx;
    logic                      moved;

    assign parent_idx = (idx_reg - HEAP_AW'(1)) >> 1;
    assign lidx       = {idx_reg, 1'b1};
    assign ridx       = lidx + CNT_W'(1);
    assign cnt_dec    = cnt_reg - CNT_W'(1);

    always_comb
    begin
        best     = val_reg;
        best_idx = idx_reg;
        moved    = 1'b0;
        if (lv_reg < best)
        begin
            best     = lv_reg;
            best_idx = lidx[HEAP_AW-1:0];
            moved    = 1'b1;
        end
        if (rv_ok_reg && (rd_data_reg < best))
        begin
            best     = rd_data_reg;
            best_idx = ridx[HEAP_AW-1:0];
            moved    = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        lv_next    = lv_reg;
        top_next   = top_reg;
        rv_ok_next = rv_ok_reg;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = val_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                unique case (cmd.op)
                    HOP_PUSH:
                    begin
                        if (!cnt_reg[HEAP_AW])
                        begin
                            idx_next   = cnt_reg[HEAP_AW-1:0];
                            cnt_next   = cnt_reg + CNT_W'(1);
                            val_next   = cmd.value;
                            state_next = S_UP_CHK;
                        end
                    end
                    HOP_POP:
                    begin
                        if (cnt_reg == '0)
                            top_next = '0;
                        else
                            state_next = S_POP_TOP;
                    end
                    HOP_CLEAR: cnt_next = '0;
                    HOP_NOP:   ;
                    default:   ;
                endcase
            end
            S_UP_CHK:
            begin
                if (idx_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_addr    = parent_idx;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (rd_data_reg <= val_reg)
                    state_next = S_IDLE;
                else
                begin
                    wr_data    = rd_data_reg;
                    idx_next   = parent_idx;
                    state_next = S_UP_CHK;
                end
            end
            S_POP_TOP:
            begin
                top_next   = rd_data_reg;
                rd_addr    = cnt_dec[HEAP_AW-1:0];
                state_next = S_POP_LAST;
            end
            S_POP_LAST:
            begin
                val_next   = rd_data_reg;
                cnt_next   = cnt_dec;
                idx_next   = '0;
                state_next = (cnt_dec == '0) ? S_IDLE : S_DN_L;
            end
            S_DN_L:
            begin
                if (lidx < cnt_reg)
                begin
                    rd_addr    = lidx[HEAP_AW-1:0];
                    state_next = S_DN_R;
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DN_R:
            begin
                lv_next    = rd_data_reg;
                rv_ok_next = (ridx < cnt_reg);
                rd_addr    = ridx[HEAP_AW-1:0];
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                wr_en   = 1'b1;
                wr_data = best;
                if (moved)
                begin
                    idx_next   = best_idx;
                    state_next = S_DN_L;
                end
                else
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            top_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            top_reg   <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        val_reg   <= val_next;
        lv_reg    <= lv_next;
        rv_ok_reg <= rv_ok_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign stat.idle  = (state_reg == S_IDLE);
    assign stat.count = cnt_reg;
    assign stat.top   = top_reg;

endmodule

// File: sv/running_median_two_heaps.sv
// Top level of the two-heap running median block.
//
// Input channel (in_valid / in_stall / in_data): one signed sample per
// transfer, with a first flag that empties the store and starts a new
// sequence. Output channel (out_valid / out_stall / out_data): the median so
// far, the sample count and an overflow flag. A result is produced for the
// first sample and for every odd-numbered sample after it; an even-numbered
// sample only enters the store. A sample that arrives with 1024 samples
// already held is dropped and gives a result with overflow set.
// One item at a time: in_stall is high while a sample is being worked on.
// A sample's push runs a sift-up that reads the parent and then compares and
// writes at each heap level, and an odd sample adds a rebalance whose pop
// reads the top and the last entry and then sifts down, reading the left and
// right child and then comparing and writing at each level.
// The output register holds a finished result, so the next sample is taken
// while the receiver stalls; only a new result waits for the register.
// Reset empties both heaps and clears the median and count; memory contents
// are not cleared, since an entry is read only after it was written.
module running_median_two_heaps (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  rmth_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output rmth_pkg::out_t out_data
);
    import rmth_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_WAIT,
        S_REBAL,
        S_REBAL_WAIT,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic signed [31:0]  median_reg, median_next;
    logic [SEEN_W-1:0]   seen_reg, seen_next;
    logic                ovf_reg, ovf_next;
    logic                dir_reg, dir_next;
    logic                out_valid_reg, out_valid_next;
    out_t                out_data_reg, out_data_next;

    heap_cmd_t           low_cmd, high_cmd;
    heap_stat_t          low_stat, high_stat;

    logic                accept;
    logic                start;
    logic                both_idle;

    assign accept    = in_valid && !in_stall;
    assign start     = in_data.first || (seen_reg == '0);
    assign both_idle = low_stat.idle && high_stat.idle;
    assign in_stall  = (state_reg != S_IDLE);

    // The low heap keeps bit-inverted values so both heaps run as min-heaps.
    always_comb
    begin
        state_next     = state_reg;
        median_next    = median_reg;
        seen_next      = seen_reg;
        ovf_next       = ovf_reg;
        dir_next       = dir_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        low_cmd        = '{op: HOP_NOP, value: ~median_reg};
        high_cmd       = '{op: HOP_NOP, value: median_reg};
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (start)
                    begin
                        low_cmd.op  = HOP_CLEAR;
                        high_cmd.op = HOP_CLEAR;
                        median_next = in_data.sample;
                        seen_next   = SEEN_W'(1);
                        ovf_next    = 1'b0;
                        state_next  = S_EMIT;
                    end
                    else if (seen_reg >= SEEN_W'(CAPACITY))
                    begin
                        ovf_next   = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        if (in_data.sample > median_reg)
                        begin
                            high_cmd.op    = HOP_PUSH;
                            high_cmd.value = in_data.sample;
                        end
                        else
                        begin
                            low_cmd.op    = HOP_PUSH;
                            low_cmd.value = ~in_data.sample;
                        end
                        seen_next  = seen_reg + SEEN_W'(1);
                        ovf_next   = 1'b0;
                        state_next = S_PUSH_WAIT;
                    end
                end
            end
            S_PUSH_WAIT:
            begin
                if (both_idle)
                    state_next = seen_reg[0] ? S_REBAL : S_IDLE;
            end
            S_REBAL:
            begin
                priority if (high_stat.count > low_stat.count)
                begin
                    // move the median down, take the smallest high value up
                    low_cmd.op  = HOP_PUSH;
                    high_cmd.op = HOP_POP;
                    dir_next    = 1'b1;
                    state_next  = S_REBAL_WAIT;
                end
                else if (high_stat.count < low_stat.count)
                begin
                    high_cmd.op = HOP_PUSH;
                    low_cmd.op  = HOP_POP;
                    dir_next    = 1'b0;
                    state_next  = S_REBAL_WAIT;
                end
                else
                    state_next = S_EMIT;
            end
            S_REBAL_WAIT:
            begin
                if (both_idle)
                begin
                    median_next = dir_reg ? high_stat.top : ~low_stat.top;
                    state_next  = S_REBAL;
                end
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.median     = median_reg;
                    out_data_next.items_seen = seen_reg;
                    out_data_next.overflow   = ovf_reg;
                    state_next               = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            median_reg    <= '0;
            seen_reg      <= '0;
            ovf_reg       <= 1'b0;
            dir_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            median_reg    <= median_next;
            seen_reg      <= seen_next;
            ovf_reg       <= ovf_next;
            dir_reg       <= dir_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    rmth_heap u_low_heap (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (low_cmd),
        .stat  (low_stat)
    );

    rmth_heap u_high_heap (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (high_cmd),
        .stat  (high_stat)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: sv/rmth_checker.sv
// Port-level checks for the running median block, bound to its top level.
module rmth_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input rmth_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_stall,
    input rmth_pkg::out_t out_data
);
    import rmth_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_odd_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.overflow |-> out_data.items_seen[0])
        else $error("normal result on even count");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.overflow |-> out_data.items_seen == SEEN_W'(CAPACITY))
        else $error("overflow result without full store");

    a_stall_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second sample taken while first in work");

endmodule

bind running_median_two_heaps rmth_checker u_rmth_checker (.*);
